FILE: rtl/fbpa_pkg.sv
// fbpa_pkg: shared widths, defaults and codes of the fixed block pool allocator
package fbpa_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int ADDR_WIDTH_DEF = 32;

    localparam int FIELD_W  = 32;
    localparam int SIZE_W   = 17;
    localparam int ACTIVE_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [FIELD_W-1:0]  BASE_RST   = '0;
    localparam logic [SIZE_W-1:0]   SIZE_RST   = SIZE_W'(64);
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = ACTIVE_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS  = 2'd0,
        CFG_BLOCK_SIZE    = 2'd1,
        CFG_ACTIVE_BLOCKS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_NOT_IN_POOL = 2'd2,
        ST_NO_SLOT     = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

endpackage

FILE: rtl/fixed_block_pool_allocator_top.sv
// fixed_block_pool_allocator_top: slot table allocator with a sequencer, a multiply/add and an adder/compare
//
// Hands out fixed-size blocks from a pool at the base address register. A request is taken when
// start is high and busy is low; its one result appears on o_block_address/o_status for exactly
// one cycle with o_result_valid, and the receiver cannot stall it. The slot table is a memory
// with one read and one write port, walked one slot per cycle; an allocate walks it for the
// first filled slot. A free walks the block addresses with one adder and comparator, one block
// per cycle, then walks the slots for an empty one. After reset the block is busy while the
// slot table is loaded with index i in slot i. Config writes are always taken and must only be
// issued while busy is low.
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [FIELD_W-1:0]   i_address,
    output logic                 o_result_valid,
    output logic [FIELD_W-1:0]   o_block_address,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]   i_cfg_data
);

    localparam int AW = ADDR_WIDTH;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = (CW > ACTIVE_W) ? CW : ACTIVE_W;
    localparam int PW = IW + SIZE_W;

    typedef struct packed {
        logic          vld;
        logic [IW-1:0] idx;
    } t_slot;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_ALLOC  = 7'b0000100,
        S_AMUL   = 7'b0001000,
        S_AADD   = 7'b0010000,
        S_FMATCH = 7'b0100000,
        S_FSLOT  = 7'b1000000
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_ptr;
    logic                r_p1;
    logic [IW-1:0]       r_chk;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_blk;
    logic [PW-1:0]       r_prod;
    logic [AW-1:0]       r_acc;
    logic [AW-1:0]       r_key;
    logic [FIELD_W-1:0]  r_base;
    logic [SIZE_W-1:0]   r_size;
    logic [ACTIVE_W-1:0] r_active;
    logic                r_res_vld;
    logic [FIELD_W-1:0]  r_res_addr;
    t_status             r_res_status;

    t_slot               r_mem [SLOTS];
    t_slot               r_rd_data;

    logic [NW-1:0]       act_ext;
    logic [CW-1:0]       live_cnt;
    logic                ptr_live;
    logic                hit;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    t_slot               mem_wd;

    // active count above the table depth behaves as the depth
    always_comb begin
        act_ext  = NW'(r_active);
        live_cnt = (act_ext > NW'(SLOTS)) ? CW'(SLOTS) : CW'(act_ext);
        ptr_live = (r_ptr < live_cnt);
    end

    // r_rd_data holds slot r_chk whenever r_p1 is set
    always_comb begin
        hit = 1'b0;
        if (r_state == S_ALLOC) begin
            hit = r_p1 && r_rd_data.vld;
        end else if (r_state == S_FSLOT) begin
            hit = r_p1 && !r_rd_data.vld;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_chk;
        mem_wd = '{vld: 1'b1, idx: r_blk};
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_ptr[IW-1:0];
                mem_wd = '{vld: 1'b1, idx: r_ptr[IW-1:0]};
            end
            S_ALLOC: begin
                mem_we = hit;
                mem_wd = '{vld: 1'b0, idx: r_rd_data.idx};
            end
            S_FSLOT: begin
                mem_we = hit;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_ptr[IW-1:0]];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_RST;
            r_size   <= SIZE_RST;
            r_active <= ACTIVE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_ADDRESS:  r_base   <= i_cfg_data;
                CFG_BLOCK_SIZE:    r_size   <= i_cfg_data[SIZE_W-1:0];
                CFG_ACTIVE_BLOCKS: r_active <= i_cfg_data[ACTIVE_W-1:0];
                default: begin
                    r_base <= r_base;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ptr     <= '0;
            r_p1      <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            r_p1      <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == CW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_ptr <= '0;
                    if (start) begin
                        r_acc <= AW'(r_base);
                        r_key <= AW'(i_address);
                        if (i_opcode == OP_FREE) begin
                            r_state <= S_FMATCH;
                        end else begin
                            r_state <= S_ALLOC;
                        end
                    end
                end
                S_ALLOC, S_FSLOT: begin
                    // one slot read issued per cycle, checked in the next cycle
                    r_p1  <= ptr_live && !hit;
                    r_chk <= r_ptr[IW-1:0];
                    if (ptr_live) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (hit) begin
                        if (r_state == S_ALLOC) begin
                            r_idx   <= r_rd_data.idx;
                            r_state <= S_AMUL;
                        end else begin
                            r_res_vld    <= 1'b1;
                            r_res_addr   <= '0;
                            r_res_status <= ST_OK;
                            r_state      <= S_IDLE;
                        end
                    end else if (!ptr_live && !r_p1) begin
                        r_res_vld <= 1'b1;
                        if (r_state == S_ALLOC) begin
                            r_res_addr   <= FIELD_W'(AW'(r_base));
                            r_res_status <= ST_FULL;
                        end else begin
                            r_res_addr   <= '0;
                            r_res_status <= ST_NO_SLOT;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_AMUL: begin
                    r_prod  <= PW'(r_idx) * PW'(r_size);
                    r_state <= S_AADD;
                end
                S_AADD: begin
                    r_res_vld    <= 1'b1;
                    r_res_addr   <= FIELD_W'(AW'(r_base) + AW'(r_prod));
                    r_res_status <= ST_OK;
                    r_state      <= S_IDLE;
                end
                S_FMATCH: begin
                    // running block address, lowest matching block wins
                    if (!ptr_live) begin
                        r_res_vld    <= 1'b1;
                        r_res_addr   <= '0;
                        r_res_status <= ST_NOT_IN_POOL;
                        r_state      <= S_IDLE;
                    end else if (r_acc == r_key) begin
                        r_blk   <= r_ptr[IW-1:0];
                        r_ptr   <= '0;
                        r_state <= S_FSLOT;
                    end else begin
                        r_acc <= r_acc + AW'(r_size);
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_result_valid  = r_res_vld;
    assign o_block_address = r_res_addr;
    assign o_status        = r_res_status;

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking testbench of the fixed block pool allocator with its own slot table model
`timescale 1ns / 100ps

module tb;
    import fbpa_pkg::*;

    localparam int POOL_SLOTS = SLOTS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] block_address;
        t_status            status;
    } pool_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [FIELD_W-1:0]   i_address;
    logic                 o_result_valid;
    logic [FIELD_W-1:0]   o_block_address;
    logic [1:0]           o_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FIELD_W-1:0]   i_cfg_data;

    // model state: pool registers and slot table
    logic [FIELD_W-1:0]  pool_base;
    logic [SIZE_W-1:0]   pool_block_size;
    logic [ACTIVE_W-1:0] pool_active;
    bit                  slot_holds[POOL_SLOTS];
    logic [6:0]          slot_block[POOL_SLOTS];
    int                  granted_index;

    pool_result_t pending_results[$];
    int           held_blocks[$];
    bit           gaps_on;

    int mismatch_count;
    int requests_sent;
    int allocs_sent;
    int frees_sent;
    int results_checked;
    int status_seen[4];

    fixed_block_pool_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .o_result_valid  (o_result_valid),
        .o_block_address (o_block_address),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int live_slots();
        return (int'(pool_active) > POOL_SLOTS) ? POOL_SLOTS : int'(pool_active);
    endfunction

    function automatic logic [FIELD_W-1:0] block_start(input int unsigned idx);
        logic [63:0] sum;
        sum = 64'(pool_base) + 64'(idx) * 64'(pool_block_size);
        return sum[FIELD_W-1:0];
    endfunction

    // allocate takes the first filled slot; free finds the lowest matching block
    // and drops its index into the first empty slot
    function automatic pool_result_t pool_request(input t_opcode op,
                                                  input logic [FIELD_W-1:0] addr);
        pool_result_t r;
        int n;
        n = live_slots();
        granted_index = -1;
        r.block_address = '0;
        r.status = ST_NOT_IN_POOL;
        if (op == OP_ALLOC) begin
            r.block_address = pool_base;
            r.status = ST_FULL;
            for (int x = 0; x < n; x++) begin
                if (slot_holds[x]) begin
                    slot_holds[x] = 1'b0;
                    granted_index = slot_block[x];
                    r.block_address = block_start(slot_block[x]);
                    r.status = ST_OK;
                    break;
                end
            end
        end else begin
            for (int x = 0; x < n; x++) begin
                if (block_start(x) == addr) begin
                    r.status = ST_NO_SLOT;
                    for (int y = 0; y < n; y++) begin
                        if (!slot_holds[y]) begin
                            slot_holds[y] = 1'b1;
                            slot_block[y] = 7'(x);
                            r.status = ST_OK;
                            break;
                        end
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    // leaves start high so back-to-back requests need no extra edge
    task automatic send_request(input t_opcode op, input logic [FIELD_W-1:0] addr);
        pool_result_t r;
        start     <= 1'b1;
        i_opcode  <= op;
        i_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = pool_request(op, addr);
        pending_results.push_back(r);
        requests_sent++;
        if (op == OP_ALLOC) begin
            allocs_sent++;
            if (granted_index >= 0) held_blocks.push_back(granted_index);
        end else begin
            frees_sent++;
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FIELD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_BASE_ADDRESS:  pool_base = data;
            CFG_BLOCK_SIZE:    pool_block_size = data[SIZE_W-1:0];
            CFG_ACTIVE_BLOCKS: pool_active = data[ACTIVE_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy !== 1'b0);
    endtask

    task automatic set_pool(input logic [FIELD_W-1:0] base, input int unsigned size,
                            input int unsigned active);
        wait_idle();
        write_register(CFG_BASE_ADDRESS, base);
        write_register(CFG_BLOCK_SIZE, FIELD_W'(size));
        write_register(CFG_ACTIVE_BLOCKS, FIELD_W'(active));
    endtask

    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // mostly allocate / free-what-was-allocated, plus double frees and stray addresses
    task automatic random_request();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 80 && held_blocks.size() == 0)) begin
            send_request(OP_ALLOC, $urandom);
        end else if (pick < 80) begin
            k = $urandom_range(0, held_blocks.size() - 1);
            send_request(OP_FREE, block_start(held_blocks[k]));
            held_blocks.delete(k);
        end else if (pick < 90) begin
            send_request(OP_FREE, block_start($urandom_range(0, live_slots() + 2)));
        end else begin
            send_request(OP_FREE, $urandom);
        end
    endtask

    task automatic random_pool_setting();
        logic [FIELD_W-1:0] base;
        int unsigned size;
        int unsigned active;
        case ($urandom_range(0, 3))
            0: base = '0;
            1: base = $urandom;
            2: base = 32'hFFFF_FF00 | FIELD_W'($urandom_range(0, 255));
            default: base = $urandom & 32'hFFFF_0000;
        endcase
        case ($urandom_range(0, 4))
            0: size = 1;
            1: size = 65536;
            2: size = $urandom_range(1, 65535);
            3: size = 64;
            default: size = 1 << $urandom_range(0, 16);
        endcase
        case ($urandom_range(0, 5))
            0: active = 64;
            1: active = $urandom_range(1, 8);
            2: active = $urandom_range(1, 64);
            3: active = $urandom_range(65, 127);
            4: active = 1;
            default: active = 64;
        endcase
        set_pool(base, size, active);
    endtask

    task automatic test_reset_defaults();
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_ALLOC, $urandom);
        send_request(OP_FREE, block_start(1));
        send_request(OP_FREE, block_start(1));   // double free goes unnoticed
        send_request(OP_ALLOC, 32'h5555_5555);
        send_request(OP_ALLOC, 32'hAAAA_AAAA);
    endtask

    task automatic test_pool_limits();
        set_pool(32'h0000_1000, 16, 2);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 32'h0000_1005);
        send_request(OP_FREE, 32'h0000_1000);
        send_request(OP_FREE, 32'h0000_1010);
        send_request(OP_FREE, 32'h0000_1000);
    endtask

    task automatic test_odd_settings();
        // zero block size: every block sits on the base
        set_pool(32'hFFFF_FFFF, 0, 127);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        // no active blocks
        set_pool(32'h8000_0000, 65536, 0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 32'h8000_0000);
        wait_idle();
        write_register(CFG_SPARE_IDX, $urandom);
        // addresses wrap past the top of the space
        set_pool(32'hFFFF_8000, 65536, 64);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 32'h0000_7FFF);
        send_request(OP_ALLOC, '0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            random_pool_setting();
            held_blocks.delete();
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (75) begin
                sender_gap();
                random_request();
            end
        end
    endtask

    task automatic test_back_to_back();
        random_pool_setting();
        gaps_on = 1'b0;
        repeat (50) random_request();
    endtask

    always @(posedge i_clk) begin
        pool_result_t want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: block_address %h status %0d",
                       o_block_address, o_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[o_status]++;
                if (o_block_address !== want.block_address) begin
                    $error("block_address: expected %h, actual %h",
                           want.block_address, o_block_address);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int guard;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_opcode    <= OP_ALLOC;
        i_address   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BASE_ADDRESS;
        i_cfg_data  <= '0;
        pool_base       = BASE_RST;
        pool_block_size = SIZE_RST;
        pool_active     = ACTIVE_RST;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_holds[i] = 1'b1;
            slot_block[i] = 7'(i);
        end
        gaps_on = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_pool_limits();
        test_odd_settings();
        test_random_traffic();
        test_back_to_back();

        start <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while ((pending_results.size() != 0 || busy !== 1'b0) && guard < 20000);
        if (guard >= 20000) begin
            $display("drain timeout: %0d results still outstanding", pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            repeat (200) @(posedge i_clk);
            $display("covered %0d requests (%0d allocate, %0d free), %0d results checked",
                     requests_sent, allocs_sent, frees_sent, results_checked);
            $display("status counts: ok %0d, pool full %0d, not in pool %0d, no empty slot %0d",
                     status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_IN_POOL],
                     status_seen[ST_NO_SLOT]);
            if (mismatch_count == 0 && pending_results.size() == 0) begin
                $display("end of test: clean");
            end else begin
                $display("end of test: mismatches");
            end
            $finish;
        end
    end

endmodule

FILE: sim.f
rtl/fbpa_pkg.sv
rtl/fixed_block_pool_allocator_top.sv
tb/sv/tb.sv
